// ===== rtl/bmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants of the bidirectional motor PWM unit.
// ----------------------------------------------------------------------------
package bmp_pkg;

    // Default number of motors
    localparam int MOTORS_DEF = 4;

    // Field widths
    localparam int ACTION_W  = 2;
    localparam int INDEX_W   = 2;
    localparam int SPEED_W   = 8;
    localparam int PERIOD_W  = 8;
    localparam int DRIVE_W   = 8;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;

    // Reset value of the period register
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd100;

    // Most negative speed and the pulse width it maps to (full on)
    localparam logic [SPEED_W-1:0] SPEED_MOST_NEG = 8'h80;
    localparam logic [SPEED_W-1:0] PULSE_FULL     = 8'hff;

    // Request kinds
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    // One input request
    typedef struct packed {
        action_t                    action;
        logic [INDEX_W-1:0]         motor_index;
        logic signed [SPEED_W-1:0]  speed;
    } item_t;

    // One result; drive_lines lands in the low bits when packed
    typedef struct packed {
        logic signed [SPEED_W-1:0]  read_speed;
        logic [DRIVE_W-1:0]         drive_lines;
    } result_t;

endpackage

// ===== rtl/bidirectional_motor_pwm_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidirectional_motor_pwm_unit
// Sign-magnitude PWM H-bridge driver for several motors, stream interface.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  s_*       in         s_tvalid/s_tready   tuser: action; tdata: index, speed
//  m_*       out        m_tvalid/m_tready   tdata: drive_lines, read_speed
//  cfg_*     in         cfg_valid/cfg_ready cfg_data: pwm_period
//
//  One request per cycle sustained while the result side is not stalled; a request
//  goes through the input register, then the state update into the result register.
//  The motor state changes in the cycle a request moves into the result register.
//  A stalled result holds; the input side keeps taking requests until both
//  registers are full. Reset clears all motor state, period returns to 100.
// ----------------------------------------------------------------------------
module bidirectional_motor_pwm_unit
#(
    parameter int MOTORS = bmp_pkg::MOTORS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bmp_pkg::S_DATA_W-1:0]    s_tdata,   // [1:0] motor_index, [9:2] speed
    input  logic [bmp_pkg::ACTION_W-1:0]    s_tuser,   // [1:0] action
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bmp_pkg::M_DATA_W-1:0]    m_tdata,   // [7:0] drive_lines, [15:8] read_speed
    // period register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bmp_pkg::PERIOD_W-1:0]    cfg_data
);
    import bmp_pkg::*;

    item_t   s_item;
    item_t   core_item;
    logic    core_valid;
    logic    core_ready;
    result_t core_result;
    result_t m_result;

    // Unpack the request
    assign s_item.action      = action_t'(s_tuser);
    assign s_item.motor_index = s_tdata[INDEX_W-1:0];
    assign s_item.speed       = s_tdata[INDEX_W+SPEED_W-1:INDEX_W];

    assign cfg_ready = 1'b1;

    // Input register
    bmp_in_stage u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_item  (core_item)
    );

    // State and result logic
    bmp_core #(.MOTORS(MOTORS)) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .step      (core_valid && core_ready),
        .item      (core_item),
        .result    (core_result)
    );

    // Result register
    bmp_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (core_valid),
        .in_ready   (core_ready),
        .in_result  (core_result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_result)
    );

    assign m_tdata = m_result;

endmodule

// ===== rtl/bmp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_in_stage
// Input register: holds one accepted request until the core consumes it.
// ----------------------------------------------------------------------------
module bmp_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bmp_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output bmp_pkg::item_t  out_item
);
    import bmp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Accept when empty or when the held request moves on this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== rtl/bmp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_core
// Motor state, PWM counter and line logic; computes one result per request.
// ----------------------------------------------------------------------------
module bmp_core
#(
    parameter int MOTORS = bmp_pkg::MOTORS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [bmp_pkg::PERIOD_W-1:0]    cfg_data,
    input  logic                            step,
    input  bmp_pkg::item_t                  item,
    output bmp_pkg::result_t                result
);
    import bmp_pkg::*;

    localparam int LINES = 2 * MOTORS;
    localparam int SHOWN = (LINES < DRIVE_W) ? LINES : DRIVE_W;

    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] tick_count_reg, tick_count_next;
    logic [SPEED_W-1:0]  pulse_reg   [MOTORS];
    logic [SPEED_W-1:0]  pulse_next  [MOTORS];
    logic [SPEED_W-1:0]  stored_reg  [MOTORS];
    logic [SPEED_W-1:0]  stored_next [MOTORS];
    logic [MOTORS-1:0]   rev_reg, rev_next;
    logic [MOTORS-1:0]   armed_reg, armed_next;
    logic [LINES-1:0]    lines_reg, lines_next;

    logic                restart;
    logic [SPEED_W-1:0]  raw;
    logic                positive;
    logic [SPEED_W-1:0]  rev_pulse;
    logic [SPEED_W-1:0]  read_value;
    logic [DRIVE_W-1:0]  drive;

    // Request decode and next state
    always_comb
    begin
        restart         = (tick_count_reg >= period_reg);
        raw             = item.speed;
        positive        = !raw[SPEED_W-1] && (raw != '0);
        // negate, with the most negative speed going to full on
        rev_pulse       = (raw == SPEED_MOST_NEG) ? PULSE_FULL : SPEED_W'(8'd0 - raw);
        tick_count_next = tick_count_reg;
        pulse_next      = pulse_reg;
        stored_next     = stored_reg;
        rev_next        = rev_reg;
        armed_next      = armed_reg;
        lines_next      = lines_reg;
        read_value      = '0;

        case (item.action)
            ACT_TICK:
            begin
                if (restart)
                begin
                    tick_count_next = '0;
                end
                else
                begin
                    tick_count_next = tick_count_reg + 8'd1;
                end
                for (int m = 0; m < MOTORS; m++)
                begin
                    if (restart)
                    begin
                        // period start: raise the active line of every running motor
                        if (pulse_reg[m] != '0)
                        begin
                            armed_next[m] = 1'b1;
                            if (rev_reg[m])
                            begin
                                lines_next[2*m+1] = 1'b1;
                            end
                            else
                            begin
                                lines_next[2*m] = 1'b1;
                            end
                        end
                    end
                    else if (armed_reg[m] && (tick_count_reg >= pulse_reg[m]))
                    begin
                        // pulse over: drop the active line
                        armed_next[m] = 1'b0;
                        if (rev_reg[m])
                        begin
                            lines_next[2*m+1] = 1'b0;
                        end
                        else
                        begin
                            lines_next[2*m] = 1'b0;
                        end
                    end
                end
            end
            ACT_WRITE:
            begin
                for (int m = 0; m < MOTORS; m++)
                begin
                    if (int'(item.motor_index) == m)
                    begin
                        stored_next[m] = raw;
                        if (positive)
                        begin
                            pulse_next[m]     = raw;
                            rev_next[m]       = 1'b0;
                            lines_next[2*m+1] = 1'b0;
                        end
                        else
                        begin
                            pulse_next[m]     = rev_pulse;
                            rev_next[m]       = 1'b1;
                            lines_next[2*m]   = 1'b0;
                        end
                    end
                end
            end
            ACT_READ:
            begin
                for (int m = 0; m < MOTORS; m++)
                begin
                    if (int'(item.motor_index) == m)
                    begin
                        read_value = stored_reg[m];
                    end
                end
            end
            default:
            begin
                // unused code: state unchanged
            end
        endcase
    end

    // Only the low lines show on the port
    always_comb
    begin
        drive             = '0;
        drive[SHOWN-1:0]  = lines_next[SHOWN-1:0];
    end

    assign result.drive_lines = drive;
    assign result.read_speed  = read_value;

    // Period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            period_reg <= cfg_data;
        end
    end

    // Motor and counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            rev_reg        <= '0;
            armed_reg      <= '0;
            lines_reg      <= '0;
            for (int m = 0; m < MOTORS; m++)
            begin
                pulse_reg[m]  <= '0;
                stored_reg[m] <= '0;
            end
        end
        else if (step)
        begin
            tick_count_reg <= tick_count_next;
            rev_reg        <= rev_next;
            armed_reg      <= armed_next;
            lines_reg      <= lines_next;
            pulse_reg      <= pulse_next;
            stored_reg     <= stored_next;
        end
    end

endmodule

// ===== rtl/bmp_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_out_stage
// Result register: holds a finished result until the sink takes it.
// ----------------------------------------------------------------------------
module bmp_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bmp_pkg::result_t  in_result,
    output logic              out_valid,
    input  logic              out_ready,
    output bmp_pkg::result_t  out_result
);
    import bmp_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // Free when empty or being drained this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            result_reg <= in_result;
        end
    end

endmodule

// ===== rtl/bmp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_checker
// Port-level checks of the motor PWM unit, bound to the top level.
// ----------------------------------------------------------------------------
module bmp_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bmp_pkg::M_DATA_W-1:0]    m_tdata
);
    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Forward and reverse line of one motor are never high together
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[7:0] & (m_tdata[7:0] >> 1) & 8'h55) == 8'h00))
        else $error("both lines of a motor driven");

    // Request side only stalls while the result side is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("request side stalled without output backpressure");

    // No result right after reset release
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

endmodule

bind bidirectional_motor_pwm_unit bmp_checker u_bmp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_bidirectional_motor_pwm_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bidirectional_motor_pwm_unit
// Self-checking bench for the sign-magnitude PWM motor driver. Tick, speed
// write and speed read requests go in over the request stream. A cycle-free
// model of the line logic predicts every result, and each result coming out
// is compared field by field with the oldest prediction. Runs cover several
// PWM periods (1 and 255 among them), random sender gaps and receiver
// stalls, and a long receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_bidirectional_motor_pwm_unit;
    import bmp_pkg::*;

    localparam int NUM_MOTORS = MOTORS_DEF;
    localparam int PAD_W      = S_DATA_W - INDEX_W - SPEED_W;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;   // [1:0] motor_index, [9:2] speed
    logic [ACTION_W-1:0]    s_tuser;   // [1:0] action
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;   // [7:0] drive_lines, [15:8] read_speed
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [PERIOD_W-1:0]    cfg_data;

    // Predicted driver state
    logic [PERIOD_W-1:0]    period_setting;
    logic [7:0]             pwm_count;
    logic [7:0]             motor_pulse   [NUM_MOTORS];
    logic                   motor_reverse [NUM_MOTORS];
    logic                   motor_armed   [NUM_MOTORS];
    logic [SPEED_W-1:0]     motor_speed   [NUM_MOTORS];
    logic [DRIVE_W-1:0]     line_state;

    result_t                predicted_line_states[$];

    // Traffic shaping
    int send_idle_pct;
    int ready_stall_pct;
    int hold_off_left;

    // Run statistics
    int mismatches;
    int ticks_seen;
    int writes_seen;
    int reads_seen;
    int results_checked;
    int period_writes;

    bidirectional_motor_pwm_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // Advance the driver model by one request and return the line levels
    function automatic result_t apply_request(item_t req);
        result_t        res;
        logic [7:0]     raw;
        int             m;
        res = '0;
        raw = req.speed;
        m   = int'(req.motor_index);
        case (req.action)
            ACT_TICK:
            begin
                if (pwm_count >= period_setting)
                begin
                    // period restart: raise active lines of running motors
                    pwm_count = '0;
                    for (int i = 0; i < NUM_MOTORS; i++)
                    begin
                        if (motor_pulse[i] != 0)
                        begin
                            line_state[2*i + motor_reverse[i]] = 1'b1;
                            motor_armed[i] = 1'b1;
                        end
                    end
                end
                else
                begin
                    // pulse end: drop lines whose width has run out
                    for (int i = 0; i < NUM_MOTORS; i++)
                    begin
                        if (motor_armed[i] && pwm_count >= motor_pulse[i])
                        begin
                            line_state[2*i + motor_reverse[i]] = 1'b0;
                            motor_armed[i] = 1'b0;
                        end
                    end
                    pwm_count = pwm_count + 8'd1;
                end
            end
            ACT_WRITE:
            begin
                motor_speed[m] = raw;
                if (raw >= 8'd1 && raw <= 8'd127)
                begin
                    motor_pulse[m]       = raw;
                    motor_reverse[m]     = 1'b0;
                    line_state[2*m + 1]  = 1'b0;
                end
                else
                begin
                    // zero and negative speeds select reverse; -128 is full on
                    motor_pulse[m]   = (raw == SPEED_MOST_NEG) ? PULSE_FULL : 8'd0 - raw;
                    motor_reverse[m] = 1'b1;
                    line_state[2*m]  = 1'b0;
                end
            end
            ACT_READ:
                res.read_speed = motor_speed[m];
            default:
                ;
        endcase
        res.drive_lines = line_state;
        return res;
    endfunction

    task automatic note_mismatch(string what, logic [7:0] want, logic [7:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("error: %s expected 0x%02h, got 0x%02h at %0t", what, want, got, $realtime);
    endtask

    // Prediction on each accepted request, check on each accepted result
    always @(posedge clk)
    begin
        item_t      req;
        result_t    got;
        result_t    want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                period_setting = cfg_data;
                period_writes++;
            end
            if (s_tvalid && s_tready)
            begin
                req.action      = action_t'(s_tuser);
                req.motor_index = s_tdata[INDEX_W-1:0];
                req.speed       = s_tdata[INDEX_W +: SPEED_W];
                predicted_line_states.push_back(apply_request(req));
                case (req.action)
                    ACT_TICK:  ticks_seen++;
                    ACT_WRITE: writes_seen++;
                    default:   reads_seen++;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (predicted_line_states.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("error: unexpected result 0x%04h at %0t", m_tdata, $realtime);
                end
                else
                begin
                    want = predicted_line_states.pop_front();
                    results_checked++;
                    if (got.drive_lines !== want.drive_lines)
                        note_mismatch("drive_lines", want.drive_lines, got.drive_lines);
                    if (got.read_speed !== want.read_speed)
                        note_mismatch("read_speed", want.read_speed, got.read_speed);
                end
            end
        end
    end

    // Result receiver: random stalls, or a counted hold-off when requested
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            m_tready      <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // Offer one request, with random gaps ahead of it, and wait until taken
    task automatic send_request(action_t act, logic [INDEX_W-1:0] idx,
                                logic signed [SPEED_W-1:0] spd);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{PAD_W{1'b0}}, spd, idx};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop offering and let every predicted result come out
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (predicted_line_states.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_pwm_period(logic [PERIOD_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly ticks so that periods complete; speeds lean to the edges
    function automatic item_t random_request();
        item_t  r;
        int     pick;
        int     mag;
        pick = $urandom_range(99);
        if (pick < 70)
            r.action = ACT_TICK;
        else if (pick < 88)
            r.action = ACT_WRITE;
        else
            r.action = ACT_READ;
        r.motor_index = INDEX_W'($urandom_range(NUM_MOTORS - 1));
        pick = $urandom_range(9);
        case (pick)
            0:       r.speed = 8'sh7f;
            1:       r.speed = 8'sh80;
            2:       r.speed = 8'sh00;
            3:       r.speed = -8'sd1;
            4, 5, 6:
            begin
                // widths around the period so that lines actually drop
                mag = $urandom_range((period_setting > 127) ? 127 : period_setting);
                r.speed = $urandom_range(1) ? 8'(mag) : 8'(-mag);
            end
            default: r.speed = SPEED_W'($urandom_range(255));
        endcase
        return r;
    endfunction

    task automatic send_random(int count);
        item_t r;
        repeat (count)
        begin
            r = random_request();
            send_request(r.action, r.motor_index, r.speed);
        end
    endtask

    // Speed extremes, every action, restart timing, direction change
    task automatic test_directed_cases();
        send_request(ACT_WRITE, 2'd0, 8'sh7f);
        send_request(ACT_WRITE, 2'd1, 8'sh80);
        send_request(ACT_WRITE, 2'd2, 8'sh00);
        send_request(ACT_WRITE, 2'd3, 8'sd1);
        send_request(ACT_TICK,  2'd0, 8'sh00);
        for (int m = 0; m < NUM_MOTORS; m++)
            send_request(ACT_READ, m[INDEX_W-1:0], 8'sh00);
        set_pwm_period(8'd3);
        repeat (7) send_request(ACT_TICK, 2'd3, 8'sh00);
        // direction flip while armed
        send_request(ACT_WRITE, 2'd3, -8'sd1);
        repeat (2) send_request(ACT_TICK, 2'd0, 8'sh00);
        send_request(ACT_WRITE, 2'd2, -8'sd2);
        repeat (4) send_request(ACT_TICK, 2'd1, 8'sh00);
        send_request(ACT_READ, 2'd2, 8'sh00);
    endtask

    // Long receiver hold-off fills the pipeline; then a full drain
    task automatic test_backpressure();
        wait_idle();
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        hold_off_left   = 64;
        send_random(24);
        wait_idle();
        send_random(12);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct,
                                       int first_count, logic [PERIOD_W-1:0] first_period,
                                       int second_count, logic [PERIOD_W-1:0] second_period);
        set_pwm_period(first_period);
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        send_random(first_count);
        set_pwm_period(second_period);
        send_random(second_count);
    endtask

    // Test sequence
    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        hold_off_left   = 0;
        mismatches      = 0;
        ticks_seen      = 0;
        writes_seen     = 0;
        reads_seen      = 0;
        results_checked = 0;
        period_writes   = 0;
        period_setting  = PERIOD_RST;
        pwm_count       = '0;
        line_state      = '0;
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            motor_pulse[m]   = '0;
            motor_reverse[m] = 1'b0;
            motor_armed[m]   = 1'b0;
            motor_speed[m]   = '0;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_cases();
        test_backpressure();
        test_random_traffic(0,  0,  150, 8'd1,                   500, 8'd255);
        test_random_traffic(79, 0,  175, PERIOD_RST,             175, 8'($urandom_range(20, 2)));
        test_random_traffic(0,  79, 175, 8'($urandom_range(20, 2)), 175, 8'd8);
        test_random_traffic(18, 18, 175, 8'd3,                   175, 8'($urandom_range(40, 2)));

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Checked %0d results: %0d ticks, %0d speed writes, %0d speed reads",
                 results_checked, ticks_seen, writes_seen, reads_seen);
        $display("across %0d period settings, with sender gaps, receiver stalls and a hold-off",
                 period_writes);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bmp_pkg.sv
rtl/bmp_in_stage.sv
rtl/bmp_core.sv
rtl/bmp_out_stage.sv
rtl/bidirectional_motor_pwm_unit.sv
rtl/bmp_checker.sv
tb/tb_bidirectional_motor_pwm_unit.sv
